// ===== rtl/tbwg_pkg.sv =====
package tbwg_pkg;

    // Internal time resolution; ports stay at the full field width.
    localparam int TIME_BITS       = 64;
    localparam int FIELD_TIME_BITS = 64;
    localparam int WIDTH_BITS      = 63;
    localparam int CMD_BITS        = 2;
    localparam int CODE_BITS       = 3;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 64;
    localparam int QUEUE_DEPTH     = 2;

    typedef logic signed [TIME_BITS-1:0]  time_t;
    typedef logic        [WIDTH_BITS-1:0] width_t;

    typedef enum logic [CMD_BITS-1:0] {
        OP_PHOTON  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [CODE_BITS-1:0] {
        WC_NONE      = 3'd0,
        WC_ADVANCED  = 3'd1,
        WC_TRIMMED   = 3'd2,
        WC_EXCEEDED  = 3'd3,
        WC_RESTARTED = 3'd4
    } win_code_t;

    typedef enum logic [CODE_BITS-1:0] {
        V_NONE     = 3'd0,
        V_PASSED   = 3'd1,
        V_DROPPED  = 3'd2,
        V_HELD     = 3'd3,
        V_END      = 3'd4,
        V_REJECTED = 3'd5
    } verdict_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_START_TIME  = 2'd0,
        REG_BIN_WIDTH   = 2'd1,
        REG_STOP_ENABLE = 2'd2,
        REG_STOP_TIME   = 2'd3
    } reg_index_t;

    typedef struct packed {
        op_t   op;
        time_t t;
    } item_t;

    typedef struct packed {
        time_t  win_start;
        width_t step_width;
        logic   stop_enable;
        time_t  stop_at;
    } cfg_t;

    // Sign-extend an internal time onto the port width.
    function automatic logic signed [FIELD_TIME_BITS-1:0] to_field(input time_t x);
        logic signed [FIELD_TIME_BITS-1:0] r;
        r = FIELD_TIME_BITS'(x);
        return r;
    endfunction

endpackage

// ===== rtl/tbwg_in_if.sv =====
interface tbwg_in_if;
    import tbwg_pkg::*;

    logic                              valid;
    logic                              ready;
    logic [CMD_BITS-1:0]               command;
    logic signed [FIELD_TIME_BITS-1:0] photon_time;

    modport source (output valid, output command, output photon_time, input ready);
    modport sink   (input valid, input command, input photon_time, output ready);
endinterface

// ===== rtl/tbwg_out_if.sv =====
interface tbwg_out_if;
    import tbwg_pkg::*;

    logic                              valid;
    logic                              ready;
    logic [CODE_BITS-1:0]              window_code;
    logic [CODE_BITS-1:0]              verdict;
    logic signed [FIELD_TIME_BITS-1:0] out_time;
    logic signed [FIELD_TIME_BITS-1:0] window_lower;
    logic signed [FIELD_TIME_BITS-1:0] window_upper;
    logic                              finished;

    modport source (output valid, output window_code, output verdict, output out_time,
                    output window_lower, output window_upper, output finished,
                    input ready);
    modport sink   (input valid, input window_code, input verdict, input out_time,
                    input window_lower, input window_upper, input finished,
                    output ready);
endinterface

// ===== rtl/tbwg_front.sv =====
module tbwg_front
    import tbwg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tbwg_in_if.sink    in_ch,
    output logic       push_valid,
    input  logic       push_ready,
    output item_t      push_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign in_ch.ready = !valid_reg || push_ready;

    always_comb
    begin
        item_next.t = in_ch.photon_time[TIME_BITS-1:0];
        unique case (in_ch.command)
            OP_PHOTON:  item_next.op = OP_PHOTON;
            OP_ADVANCE: item_next.op = OP_ADVANCE;
            OP_RESTART: item_next.op = OP_RESTART;
            default:    item_next.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg <= item_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// ===== rtl/tbwg_queue.sv =====
module tbwg_queue
    import tbwg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(QUEUE_DEPTH - 1);

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  push;
    logic                  pop;

    assign wr_ready = (count_reg != FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/tbwg_back.sv =====
module tbwg_back
    import tbwg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  item_t     q_item,
    tbwg_out_if.source out_ch
);

    localparam int SUM_BITS = ((TIME_BITS > WIDTH_BITS) ? TIME_BITS : WIDTH_BITS) + 2;
    localparam logic signed [SUM_BITS-1:0] TMAX_SUM =
        (SUM_BITS'(1) <<< (TIME_BITS - 1)) - SUM_BITS'(1);

    // a + w, saturated at the largest representable time
    function automatic time_t sat_add(input time_t a, input width_t w);
        logic signed [SUM_BITS-1:0] sum;
        sum = $signed(SUM_BITS'(a)) + $signed(SUM_BITS'(w));
        if (sum > TMAX_SUM)
            return TIME_BITS'(TMAX_SUM);
        return sum[TIME_BITS-1:0];
    endfunction

    function automatic verdict_t classify(input time_t t, input time_t lo, input time_t hi,
                                          input logic stop_en, input time_t stop);
        if (lo <= t && t < hi)
            return V_PASSED;
        if (lo > t)
            return V_DROPPED;
        if (stop_en && t >= stop)
            return V_END;
        return V_HELD;
    endfunction

    time_t     lower_reg, lower_next;
    time_t     upper_reg, upper_next;
    time_t     held_reg, held_next;
    logic      holding_reg, holding_next;
    logic      done_reg, done_next;

    logic      out_valid_reg;
    win_code_t out_code_reg;
    verdict_t  out_verdict_reg;
    time_t     out_time_reg;
    time_t     out_lower_reg;
    time_t     out_upper_reg;
    logic      out_done_reg;

    win_code_t wc;
    verdict_t  vd;
    time_t     otime;
    time_t     adv_lo, adv_hi, rst_hi;
    time_t     cls_t, cls_lo, cls_hi;
    logic      do_cls;
    logic      pop;

    assign q_ready = !out_valid_reg || out_ch.ready;
    assign pop     = q_valid && q_ready;

    assign adv_lo = sat_add(lower_reg, cfg.step_width);
    assign adv_hi = sat_add(upper_reg, cfg.step_width);
    assign rst_hi = sat_add(cfg.win_start, cfg.step_width);

    always_comb
    begin
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        held_next    = held_reg;
        holding_next = holding_reg;
        done_next    = done_reg;
        wc           = WC_NONE;
        vd           = V_NONE;
        otime        = '0;
        cls_t        = q_item.t;
        cls_lo       = lower_reg;
        cls_hi       = upper_reg;
        do_cls       = 1'b0;

        unique case (q_item.op)
            OP_PHOTON:
            begin
                otime = q_item.t;
                if (holding_reg)
                    vd = V_REJECTED;
                else if (done_reg)
                    vd = V_END;
                else
                    do_cls = 1'b1;
            end
            OP_ADVANCE:
            begin
                if (!done_reg)
                begin
                    lower_next = adv_lo;
                    upper_next = adv_hi;
                    wc         = WC_ADVANCED;
                    if (cfg.stop_enable && adv_hi > cfg.stop_at)
                    begin
                        if (adv_lo < cfg.stop_at)
                        begin
                            upper_next = cfg.stop_at;
                            wc         = WC_TRIMMED;
                        end
                        else
                        begin
                            wc           = WC_EXCEEDED;
                            done_next    = 1'b1;
                            holding_next = 1'b0;
                        end
                    end
                    // held photon gets another look at the new window
                    if (holding_next)
                    begin
                        otime  = held_reg;
                        cls_t  = held_reg;
                        cls_lo = lower_next;
                        cls_hi = upper_next;
                        do_cls = 1'b1;
                    end
                end
            end
            OP_RESTART:
            begin
                lower_next = cfg.win_start;
                upper_next = rst_hi;
                if (cfg.stop_enable && rst_hi > cfg.stop_at)
                    upper_next = cfg.stop_at;
                holding_next = 1'b0;
                done_next    = 1'b0;
                wc           = WC_RESTARTED;
            end
            OP_NONE:
            begin
            end
        endcase

        if (do_cls)
        begin
            vd = classify(cls_t, cls_lo, cls_hi, cfg.stop_enable, cfg.stop_at);
            case (vd) inside
                V_PASSED, V_DROPPED:
                    holding_next = 1'b0;
                V_END:
                begin
                    holding_next = 1'b0;
                    done_next    = 1'b1;
                end
                V_HELD:
                begin
                    holding_next = 1'b1;
                    held_next    = cls_t;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg     <= '0;
            upper_reg     <= '0;
            held_reg      <= '0;
            holding_reg   <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                lower_reg   <= lower_next;
                upper_reg   <= upper_next;
                held_reg    <= held_next;
                holding_reg <= holding_next;
                done_reg    <= done_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_code_reg    <= wc;
            out_verdict_reg <= vd;
            out_time_reg    <= otime;
            out_lower_reg   <= lower_next;
            out_upper_reg   <= upper_next;
            out_done_reg    <= done_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.window_code  = out_code_reg;
    assign out_ch.verdict      = out_verdict_reg;
    assign out_ch.out_time     = to_field(out_time_reg);
    assign out_ch.window_lower = to_field(out_lower_reg);
    assign out_ch.window_upper = to_field(out_upper_reg);
    assign out_ch.finished     = out_done_reg;

    // a held photon and the finished flag exclude each other
    a_hold_vs_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(holding_reg && done_reg))
        else $error("holding and finished both set");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.op == OP_PHOTON && holding_reg)
        |=> (out_verdict_reg == V_REJECTED && holding_reg && $stable(held_reg)))
        else $error("photon during hold not rejected cleanly");

    a_adv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.op == OP_ADVANCE && done_reg)
        |=> (out_code_reg == WC_NONE && $stable(lower_reg) && $stable(upper_reg)))
        else $error("advance after finish moved the window");

    a_exceed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_code_reg == WC_EXCEEDED)
        |-> (out_done_reg && out_verdict_reg == V_NONE))
        else $error("exceeded result without finish");

endmodule

// ===== rtl/time_bin_window_gate.sv =====
// Time-bin window gate.
// in_ch  : command beats (photon, advance, restart) with the photon time.
// out_ch : exactly one result beat per command beat, in order: window code,
//          verdict, photon time the verdict refers to, window bounds after the
//          command, and the finished flag.
// cfg_*  : register writes (start time, bin width, stop enable, stop time),
//          done while no command is in flight.
// Path: a beat accepted on in_ch passes the front register, then the queue,
// then the result register of the back end, before it shows up on out_ch.
// Throughput: one beat per cycle while out_ch.ready stays high, set by the window
// update in the back end (saturating add, stop compare, reclassification of a
// held photon).
// A stalled receiver holds the result register; the two-entry queue and the
// front register keep taking beats until they fill, then in_ch.ready drops.
// Reset clears the control and configuration registers, the window to [0,0) and all pending beats.
module time_bin_window_gate
    import tbwg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    tbwg_in_if.sink                   in_ch,
    tbwg_out_if.source                out_ch,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // configuration registers; times keep their low TIME_BITS bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_TIME:  cfg_reg.win_start   <= cfg_data[TIME_BITS-1:0];
                REG_BIN_WIDTH:   cfg_reg.step_width  <= cfg_data[WIDTH_BITS-1:0];
                REG_STOP_ENABLE: cfg_reg.stop_enable <= cfg_data[0];
                REG_STOP_TIME:   cfg_reg.stop_at     <= cfg_data[TIME_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: take the beat, decode the command
    tbwg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue between front and back
    tbwg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // back: window state, classification, result register
    tbwg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .out_ch  (out_ch)
    );

endmodule
